FILE: design/lsu_pkg.sv
// Shared types and constants of the load/store unit: field layout of the
// request and result words, opcodes, sequencer states and access kinds.
// No dependencies.
package lsu_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam int IN_W  = 24;
  localparam int OUT_W = 120;

  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_ACC_LSB    = 1;
  localparam int OUT_FLAGS_LSB  = 9;
  localparam int OUT_BC_LSB     = 17;
  localparam int OUT_DE_LSB     = 33;
  localparam int OUT_HL_LSB     = 49;
  localparam int OUT_SP_LSB     = 65;
  localparam int OUT_WK_LSB     = 81;
  localparam int OUT_WA_LSB     = 83;
  localparam int OUT_WV_LSB     = 99;
  localparam int OUT_USED_W     = 115;

  typedef logic [3:0][15:0] pairs_t;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_AF = 2'd3;

  localparam logic [2:0] R8_MEM = 3'd6;
  localparam logic [2:0] R8_A   = 3'd7;

  localparam logic [7:0] HIGH_PAGE = 8'hff;

  localparam logic [1:0] GRP_LD_R_R   = 2'b01;
  localparam logic [7:0] MASK_R8      = 8'hc7;
  localparam logic [7:0] PAT_LD_R_N   = 8'h06;
  localparam logic [7:0] MASK_PAIR    = 8'hcf;
  localparam logic [7:0] PAT_LD_RR_NN = 8'h01;
  localparam logic [7:0] PAT_PUSH     = 8'hc5;
  localparam logic [7:0] PAT_POP      = 8'hc1;

  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] OP_LD_IBC_A  = 8'h02;
  localparam logic [7:0] OP_LD_IDE_A  = 8'h12;
  localparam logic [7:0] OP_LDI_HL_A  = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A  = 8'h32;
  localparam logic [7:0] OP_LD_A_IBC  = 8'h0a;
  localparam logic [7:0] OP_LD_A_IDE  = 8'h1a;
  localparam logic [7:0] OP_LDI_A_HL  = 8'h2a;
  localparam logic [7:0] OP_LDD_A_HL  = 8'h3a;
  localparam logic [7:0] OP_LD_NN_SP  = 8'h08;
  localparam logic [7:0] OP_LD_SP_HL  = 8'hf9;
  localparam logic [7:0] OP_LDH_N_A   = 8'he0;
  localparam logic [7:0] OP_LDH_A_N   = 8'hf0;
  localparam logic [7:0] OP_LDH_C_A   = 8'he2;
  localparam logic [7:0] OP_LDH_A_C   = 8'hf2;
  localparam logic [7:0] OP_LD_NN_A   = 8'hea;
  localparam logic [7:0] OP_LD_A_NN   = 8'hfa;
  localparam logic [7:0] OP_LD_HL_SPE = 8'hf8;
  localparam logic [7:0] OP_CCF       = 8'h3f;
  localparam logic [7:0] OP_SCF       = 8'h37;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_BYTE = 2'd1,
    WK_WORD = 2'd2
  } wkind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_LO,
    ST_RD_HI,
    ST_WR_HI
  } state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_RD8,
    ACC_RD16,
    ACC_WR8,
    ACC_WR16,
    ACC_BAD
  } acc_t;

endpackage

FILE: design/lsu_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module lsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/cpu_load_store_unit.sv
// Load/store unit top level: register file, sequencer and result register.
// Depends on lsu_pkg and lsu_ram.
//
//   channel  direction  contents
//   in_*     request    command [7:0], immediate [23:8]
//   out_*    result     status, A, F, BC, DE, HL, SP, write kind/address/value
//
// Register-only, error and byte-store requests end in ST_EXEC; byte loads go on to
// ST_RD_LO, word stores to ST_WR_HI and POP to ST_RD_LO, ST_RD_HI (single memory port).
// The next request is taken once the sequencer is idle and the result
// register is empty or being drained. Reset clears the registers and SP;
// memory contents stay undefined until written.
module cpu_load_store_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command [7:0], immediate [23:8]
  input  logic [lsu_pkg::IN_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status [0], acc_out [8:1], flags_out [16:9], bc_out [32:17], de_out [48:33],
  // hl_out [64:49], sp_out [80:65], write_kind [82:81],
  // write_address [98:83], write_value [114:99], zeros above
  output logic [lsu_pkg::OUT_W-1:0] out_tdata
);

  localparam int AB = lsu_pkg::ADDR_BITS;

  lsu_pkg::state_t state_r, state_nxt;
  lsu_pkg::acc_t   acc_r, dec_acc;
  lsu_pkg::pairs_t pairs_r, pairs_nxt, dec_pairs;
  logic [15:0]     sp_r, sp_nxt, dec_sp;
  logic [7:0]      op_r;
  logic [15:0]     imm_r;
  logic [AB-1:0]   addr_r;
  logic [15:0]     wv_r;
  logic [7:0]      lo_r;
  logic            out_valid_r, out_valid_nxt;
  logic [lsu_pkg::OUT_W-1:0] out_data_r, res;

  logic [15:0]     dec_addr, dec_wval;
  logic            in_acc, fin, res_bad;
  logic            ram_we;
  logic [AB-1:0]   ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic [1:0]      res_wk;
  logic [15:0]     res_wa, res_wv, pop_val, hl, sext;
  logic [7:0]      imm8, fl;
  logic [2:0]      dst, src, rd_code;
  logic [1:0]      pair;
  logic [4:0]      nib_sum;
  logic [8:0]      byte_sum;

  function automatic logic [7:0] get_r8(lsu_pkg::pairs_t p, logic [2:0] code);
    logic [15:0] w;
    w = p[code[2:1]];
    if (code == lsu_pkg::R8_A) begin
      return p[lsu_pkg::PAIR_AF][15:8];
    end
    return code[0] ? w[7:0] : w[15:8];
  endfunction

  function automatic lsu_pkg::pairs_t put_r8(lsu_pkg::pairs_t p, logic [2:0] code,
                                             logic [7:0] v);
    lsu_pkg::pairs_t q;
    q = p;
    if (code == lsu_pkg::R8_A) begin
      q[lsu_pkg::PAIR_AF][15:8] = v;
    end else if (code[0]) begin
      q[code[2:1]][7:0] = v;
    end else begin
      q[code[2:1]][15:8] = v;
    end
    return q;
  endfunction

  assign in_acc   = in_tvalid && in_tready;
  assign imm8     = imm_r[7:0];
  assign dst      = op_r[5:3];
  assign src      = op_r[2:0];
  assign pair     = op_r[5:4];
  assign hl       = pairs_r[lsu_pkg::PAIR_HL];
  assign fl       = pairs_r[lsu_pkg::PAIR_AF][7:0];
  assign nib_sum  = {1'b0, sp_r[3:0]} + {1'b0, imm8[3:0]};
  assign byte_sum = {1'b0, sp_r[7:0]} + {1'b0, imm8};
  assign sext     = {{8{imm8[7]}}, imm8};
  assign rd_code  = (op_r[7:6] == lsu_pkg::GRP_LD_R_R) ? dst : lsu_pkg::R8_A;
  assign pop_val  = (pair == lsu_pkg::PAIR_AF) ? {ram_rdata, lo_r[7:4], 4'h0}
                                               : {ram_rdata, lo_r};

  always_comb begin : decode
    dec_acc   = lsu_pkg::ACC_NONE;
    dec_addr  = 16'h0000;
    dec_wval  = 16'h0000;
    dec_pairs = pairs_r;
    dec_sp    = sp_r;
    if (op_r[7:6] == lsu_pkg::GRP_LD_R_R && op_r != lsu_pkg::OP_HALT) begin
      if (src == lsu_pkg::R8_MEM) begin
        dec_acc  = lsu_pkg::ACC_RD8;
        dec_addr = hl;
      end else if (dst == lsu_pkg::R8_MEM) begin
        dec_acc  = lsu_pkg::ACC_WR8;
        dec_addr = hl;
        dec_wval = {8'h00, get_r8(pairs_r, src)};
      end else begin
        dec_pairs = put_r8(pairs_r, dst, get_r8(pairs_r, src));
      end
    end else if ((op_r & lsu_pkg::MASK_R8) == lsu_pkg::PAT_LD_R_N) begin
      if (dst == lsu_pkg::R8_MEM) begin
        dec_acc  = lsu_pkg::ACC_WR8;
        dec_addr = hl;
        dec_wval = {8'h00, imm8};
      end else begin
        dec_pairs = put_r8(pairs_r, dst, imm8);
      end
    end else if ((op_r & lsu_pkg::MASK_PAIR) == lsu_pkg::PAT_LD_RR_NN) begin
      if (pair == lsu_pkg::PAIR_AF) begin
        dec_sp = imm_r;
      end else begin
        dec_pairs[pair] = imm_r;
      end
    end else if ((op_r & lsu_pkg::MASK_PAIR) == lsu_pkg::PAT_PUSH) begin
      dec_acc  = lsu_pkg::ACC_WR16;
      dec_sp   = sp_r - 16'd2;
      dec_addr = sp_r - 16'd2;
      dec_wval = pairs_r[pair];
    end else if ((op_r & lsu_pkg::MASK_PAIR) == lsu_pkg::PAT_POP) begin
      dec_acc  = lsu_pkg::ACC_RD16;
      dec_addr = sp_r;
      dec_sp   = sp_r + 16'd2;
    end else begin
      case (op_r)
        lsu_pkg::OP_LD_IBC_A, lsu_pkg::OP_LD_IDE_A: begin
          dec_acc  = lsu_pkg::ACC_WR8;
          dec_addr = pairs_r[op_r[5:4]];
          dec_wval = {8'h00, pairs_r[lsu_pkg::PAIR_AF][15:8]};
        end
        lsu_pkg::OP_LDI_HL_A, lsu_pkg::OP_LDD_HL_A: begin
          dec_acc  = lsu_pkg::ACC_WR8;
          dec_addr = hl;
          dec_wval = {8'h00, pairs_r[lsu_pkg::PAIR_AF][15:8]};
          dec_pairs[lsu_pkg::PAIR_HL] = op_r[4] ? hl - 16'd1 : hl + 16'd1;
        end
        lsu_pkg::OP_LD_A_IBC, lsu_pkg::OP_LD_A_IDE: begin
          dec_acc  = lsu_pkg::ACC_RD8;
          dec_addr = pairs_r[op_r[5:4]];
        end
        lsu_pkg::OP_LDI_A_HL, lsu_pkg::OP_LDD_A_HL: begin
          dec_acc  = lsu_pkg::ACC_RD8;
          dec_addr = hl;
          dec_pairs[lsu_pkg::PAIR_HL] = op_r[4] ? hl - 16'd1 : hl + 16'd1;
        end
        lsu_pkg::OP_LD_NN_SP: begin
          dec_acc  = lsu_pkg::ACC_WR16;
          dec_addr = imm_r;
          dec_wval = sp_r;
        end
        lsu_pkg::OP_LD_SP_HL: begin
          dec_sp = hl;
        end
        lsu_pkg::OP_LDH_N_A: begin
          dec_acc  = lsu_pkg::ACC_WR8;
          dec_addr = {lsu_pkg::HIGH_PAGE, imm8};
          dec_wval = {8'h00, pairs_r[lsu_pkg::PAIR_AF][15:8]};
        end
        lsu_pkg::OP_LDH_A_N: begin
          dec_acc  = lsu_pkg::ACC_RD8;
          dec_addr = {lsu_pkg::HIGH_PAGE, imm8};
        end
        lsu_pkg::OP_LDH_C_A: begin
          dec_acc  = lsu_pkg::ACC_WR8;
          dec_addr = {lsu_pkg::HIGH_PAGE, pairs_r[lsu_pkg::PAIR_BC][7:0]};
          dec_wval = {8'h00, pairs_r[lsu_pkg::PAIR_AF][15:8]};
        end
        lsu_pkg::OP_LDH_A_C: begin
          dec_acc  = lsu_pkg::ACC_RD8;
          dec_addr = {lsu_pkg::HIGH_PAGE, pairs_r[lsu_pkg::PAIR_BC][7:0]};
        end
        lsu_pkg::OP_LD_NN_A: begin
          dec_acc  = lsu_pkg::ACC_WR8;
          dec_addr = imm_r;
          dec_wval = {8'h00, pairs_r[lsu_pkg::PAIR_AF][15:8]};
        end
        lsu_pkg::OP_LD_A_NN: begin
          dec_acc  = lsu_pkg::ACC_RD8;
          dec_addr = imm_r;
        end
        lsu_pkg::OP_LD_HL_SPE: begin
          dec_pairs[lsu_pkg::PAIR_AF][7:0] = {2'b00, nib_sum[4], byte_sum[8], fl[3:0]};
          dec_pairs[lsu_pkg::PAIR_HL]      = sp_r + sext;
        end
        lsu_pkg::OP_CCF: begin
          dec_pairs[lsu_pkg::PAIR_AF][7:0] = {fl[7], 2'b00, ~fl[4], fl[3:0]};
        end
        lsu_pkg::OP_SCF: begin
          dec_pairs[lsu_pkg::PAIR_AF][7:0] = {fl[7], 2'b00, 1'b1, fl[3:0]};
        end
        default: begin
          dec_acc = lsu_pkg::ACC_BAD;
        end
      endcase
    end
  end

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      lsu_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = lsu_pkg::ST_EXEC;
        end
      end
      lsu_pkg::ST_EXEC: begin
        case (dec_acc)
          lsu_pkg::ACC_RD8, lsu_pkg::ACC_RD16: state_nxt = lsu_pkg::ST_RD_LO;
          lsu_pkg::ACC_WR16:                   state_nxt = lsu_pkg::ST_WR_HI;
          default:                             state_nxt = lsu_pkg::ST_IDLE;
        endcase
      end
      lsu_pkg::ST_RD_LO: begin
        state_nxt = (acc_r == lsu_pkg::ACC_RD16) ? lsu_pkg::ST_RD_HI : lsu_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lsu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin : outputs
    in_tready = (state_r == lsu_pkg::ST_IDLE) && (!out_valid_r || out_tready);
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = wv_r[15:8];
    pairs_nxt = pairs_r;
    sp_nxt    = sp_r;
    fin       = 1'b0;
    res_bad   = 1'b0;
    res_wk    = lsu_pkg::WK_NONE;
    res_wa    = 16'h0000;
    res_wv    = 16'h0000;
    case (state_r)
      lsu_pkg::ST_EXEC: begin
        ram_addr  = dec_addr[AB-1:0];
        ram_wdata = dec_wval[7:0];
        ram_we    = (dec_acc == lsu_pkg::ACC_WR8) || (dec_acc == lsu_pkg::ACC_WR16);
        pairs_nxt = dec_pairs;
        sp_nxt    = dec_sp;
        res_bad   = (dec_acc == lsu_pkg::ACC_BAD);
        fin       = (dec_acc == lsu_pkg::ACC_NONE) || (dec_acc == lsu_pkg::ACC_BAD) ||
                    (dec_acc == lsu_pkg::ACC_WR8);
        if (dec_acc == lsu_pkg::ACC_WR8) begin
          res_wk = lsu_pkg::WK_BYTE;
          res_wa = 16'(dec_addr[AB-1:0]);
          res_wv = dec_wval;
        end
      end
      lsu_pkg::ST_RD_LO: begin
        ram_addr = addr_r + AB'(1);
        if (acc_r == lsu_pkg::ACC_RD8) begin
          pairs_nxt = put_r8(pairs_r, rd_code, ram_rdata);
          fin       = 1'b1;
        end
      end
      lsu_pkg::ST_RD_HI: begin
        pairs_nxt[pair] = pop_val;
        fin             = 1'b1;
      end
      lsu_pkg::ST_WR_HI: begin
        ram_addr = addr_r + AB'(1);
        ram_we   = 1'b1;
        fin      = 1'b1;
        res_wk   = lsu_pkg::WK_WORD;
        res_wa   = 16'(addr_r);
        res_wv   = wv_r;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    out_valid_nxt = fin || (out_valid_r && !out_tready);
  end

  always_comb begin : pack
    res = '0;
    res[lsu_pkg::OUT_STATUS_LSB]      = res_bad;
    res[lsu_pkg::OUT_ACC_LSB   +: 8]  = pairs_nxt[lsu_pkg::PAIR_AF][15:8];
    res[lsu_pkg::OUT_FLAGS_LSB +: 8]  = pairs_nxt[lsu_pkg::PAIR_AF][7:0];
    res[lsu_pkg::OUT_BC_LSB    +: 16] = pairs_nxt[lsu_pkg::PAIR_BC];
    res[lsu_pkg::OUT_DE_LSB    +: 16] = pairs_nxt[lsu_pkg::PAIR_DE];
    res[lsu_pkg::OUT_HL_LSB    +: 16] = pairs_nxt[lsu_pkg::PAIR_HL];
    res[lsu_pkg::OUT_SP_LSB    +: 16] = sp_nxt;
    res[lsu_pkg::OUT_WK_LSB    +: 2]  = res_wk;
    res[lsu_pkg::OUT_WA_LSB    +: 16] = res_wa;
    res[lsu_pkg::OUT_WV_LSB    +: 16] = res_wv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsu_pkg::ST_IDLE;
      acc_r       <= lsu_pkg::ACC_NONE;
      pairs_r     <= '0;
      sp_r        <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pairs_r     <= pairs_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == lsu_pkg::ST_EXEC) begin
        acc_r <= dec_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tdata[7:0];
      imm_r <= in_tdata[23:8];
    end
    if (state_r == lsu_pkg::ST_EXEC) begin
      addr_r <= dec_addr[AB-1:0];
      wv_r   <= dec_wval;
    end
    if (state_r == lsu_pkg::ST_RD_LO) begin
      lo_r <= ram_rdata;
    end
    if (fin) begin
      out_data_r <= res;
    end
  end

  lsu_ram #(
    .WIDTH (8),
    .DEPTH (lsu_pkg::MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/lsu_checker.sv
// Port-level checks of the load/store unit and the bind that attaches them.
// Depends on lsu_pkg and cpu_load_store_unit.
module lsu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [lsu_pkg::OUT_W-1:0] out_tdata
);

  logic [1:0]  wk;
  logic [15:0] wa, wv;
  logic        bad;

  assign wk  = out_tdata[lsu_pkg::OUT_WK_LSB +: 2];
  assign wa  = out_tdata[lsu_pkg::OUT_WA_LSB +: 16];
  assign wv  = out_tdata[lsu_pkg::OUT_WV_LSB +: 16];
  assign bad = out_tdata[lsu_pkg::OUT_STATUS_LSB];

  // A held result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // in_tready drops after a request is taken, while that request is in flight.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while the previous one is in flight");

  a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (wk == lsu_pkg::WK_NONE || wk == lsu_pkg::WK_BYTE ||
                    wk == lsu_pkg::WK_WORD))
    else $error("invalid write kind");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && wk == lsu_pkg::WK_NONE) |-> (wa == 16'h0000 && wv == 16'h0000))
    else $error("write fields set without a write");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && bad) |-> (wk == lsu_pkg::WK_NONE))
    else $error("unhandled opcode wrote memory");

endmodule

bind cpu_load_store_unit lsu_checker u_lsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/lsu_result_checker.sv
// Result checker for the load/store unit: keeps its own copy of the register file,
// stack pointer and memory, predicts every result and compares it field by field.
// Depends on lsu_pkg.
module lsu_result_checker
  import lsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  output int                    fail_count,
  output int                    pending,
  output pairs_t                arch_pairs,
  output logic [15:0]           arch_sp,
  output logic [MEM_DEPTH-1:0]  mem_written
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLAG_N = 6;
  localparam int FLAG_H = 5;
  localparam int FLAG_C = 4;

  typedef struct packed {
    logic        status;
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    wkind_t      wkind;
    logic [15:0] waddr;
    logic [15:0] wval;
  } arch_view_t;

  arch_view_t  arch_after_q[$];
  logic [7:0]  mem_image [0:MEM_DEPTH-1];
  wkind_t      wr_kind;
  logic [15:0] wr_addr;
  logic [15:0] wr_val;

  function automatic logic [7:0] get_r8(input logic [2:0] code);
    if (code == R8_A) return arch_pairs[PAIR_AF][15:8];
    return code[0] ? arch_pairs[code[2:1]][7:0] : arch_pairs[code[2:1]][15:8];
  endfunction

  function automatic void set_r8(input logic [2:0] code, input logic [7:0] value);
    if (code == R8_A) arch_pairs[PAIR_AF][15:8] = value;
    else if (code[0]) arch_pairs[code[2:1]][7:0] = value;
    else arch_pairs[code[2:1]][15:8] = value;
  endfunction

  function automatic void write_byte(input logic [15:0] addr, input logic [7:0] value);
    mem_image[addr] = value;
    mem_written[addr] = 1'b1;
    wr_kind = WK_BYTE;
    wr_addr = addr;
    wr_val = {8'h00, value};
  endfunction

  function automatic void write_word(input logic [15:0] addr, input logic [15:0] value);
    logic [15:0] addr_hi;
    addr_hi = addr + 16'd1;
    mem_image[addr] = value[7:0];
    mem_image[addr_hi] = value[15:8];
    mem_written[addr] = 1'b1;
    mem_written[addr_hi] = 1'b1;
    wr_kind = WK_WORD;
    wr_addr = addr;
    wr_val = value;
  endfunction

  function automatic arch_view_t execute_op(input logic [7:0] op, input logic [15:0] imm);
    arch_view_t  res;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [1:0]  pair;
    logic [15:0] hl;
    logic [15:0] bc;
    logic [15:0] sp_hi;
    logic [15:0] word;
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [4:0]  nib_sum;
    logic [8:0]  byte_sum;
    logic        bad;
    dst = op[5:3];
    src = op[2:0];
    pair = op[5:4];
    hl = arch_pairs[PAIR_HL];
    bc = arch_pairs[PAIR_BC];
    acc = arch_pairs[PAIR_AF][15:8];
    flags = arch_pairs[PAIR_AF][7:0];
    bad = 1'b0;
    wr_kind = WK_NONE;
    wr_addr = '0;
    wr_val = '0;
    if (op[7:6] == GRP_LD_R_R && op != OP_HALT) begin
      if (src == R8_MEM) set_r8(dst, mem_image[hl]);
      else if (dst == R8_MEM) write_byte(hl, get_r8(src));
      else set_r8(dst, get_r8(src));
    end else if ((op & MASK_R8) == PAT_LD_R_N) begin
      if (dst == R8_MEM) write_byte(hl, imm[7:0]);
      else set_r8(dst, imm[7:0]);
    end else if ((op & MASK_PAIR) == PAT_LD_RR_NN) begin
      if (pair == PAIR_AF) arch_sp = imm;
      else arch_pairs[pair] = imm;
    end else if ((op & MASK_PAIR) == PAT_PUSH) begin
      arch_sp = arch_sp - 16'd2;
      write_word(arch_sp, arch_pairs[pair]);
    end else if ((op & MASK_PAIR) == PAT_POP) begin
      sp_hi = arch_sp + 16'd1;
      word = {mem_image[sp_hi], mem_image[arch_sp]};
      if (pair == PAIR_AF) word[3:0] = 4'h0;
      arch_pairs[pair] = word;
      arch_sp = arch_sp + 16'd2;
    end else begin
      case (op)
        OP_LD_IBC_A: write_byte(bc, acc);
        OP_LD_IDE_A: write_byte(arch_pairs[PAIR_DE], acc);
        OP_LDI_HL_A: begin
          write_byte(hl, acc);
          arch_pairs[PAIR_HL] = hl + 16'd1;
        end
        OP_LDD_HL_A: begin
          write_byte(hl, acc);
          arch_pairs[PAIR_HL] = hl - 16'd1;
        end
        OP_LD_A_IBC: set_r8(R8_A, mem_image[bc]);
        OP_LD_A_IDE: set_r8(R8_A, mem_image[arch_pairs[PAIR_DE]]);
        OP_LDI_A_HL: begin
          set_r8(R8_A, mem_image[hl]);
          arch_pairs[PAIR_HL] = hl + 16'd1;
        end
        OP_LDD_A_HL: begin
          set_r8(R8_A, mem_image[hl]);
          arch_pairs[PAIR_HL] = hl - 16'd1;
        end
        OP_LD_NN_SP: write_word(imm, arch_sp);
        OP_LD_SP_HL: arch_sp = hl;
        OP_LDH_N_A:  write_byte({HIGH_PAGE, imm[7:0]}, acc);
        OP_LDH_A_N:  set_r8(R8_A, mem_image[{HIGH_PAGE, imm[7:0]}]);
        OP_LDH_C_A:  write_byte({HIGH_PAGE, bc[7:0]}, acc);
        OP_LDH_A_C:  set_r8(R8_A, mem_image[{HIGH_PAGE, bc[7:0]}]);
        OP_LD_NN_A:  write_byte(imm, acc);
        OP_LD_A_NN:  set_r8(R8_A, mem_image[imm]);
        OP_LD_HL_SPE: begin
          // Both carries come from the unsigned low bits, whatever the sign of e.
          nib_sum = {1'b0, arch_sp[3:0]} + {1'b0, imm[3:0]};
          byte_sum = {1'b0, arch_sp[7:0]} + {1'b0, imm[7:0]};
          flags = {4'h0, flags[3:0]};
          flags[FLAG_H] = nib_sum[4];
          flags[FLAG_C] = byte_sum[8];
          arch_pairs[PAIR_AF][7:0] = flags;
          arch_pairs[PAIR_HL] = arch_sp + {{8{imm[7]}}, imm[7:0]};
        end
        OP_CCF: begin
          flags[FLAG_N] = 1'b0;
          flags[FLAG_H] = 1'b0;
          flags[FLAG_C] = ~flags[FLAG_C];
          arch_pairs[PAIR_AF][7:0] = flags;
        end
        OP_SCF: begin
          flags[FLAG_N] = 1'b0;
          flags[FLAG_H] = 1'b0;
          flags[FLAG_C] = 1'b1;
          arch_pairs[PAIR_AF][7:0] = flags;
        end
        default: bad = 1'b1;
      endcase
    end
    res.status = bad;
    res.acc = arch_pairs[PAIR_AF][15:8];
    res.flags = arch_pairs[PAIR_AF][7:0];
    res.bc = arch_pairs[PAIR_BC];
    res.de = arch_pairs[PAIR_DE];
    res.hl = arch_pairs[PAIR_HL];
    res.sp = arch_sp;
    res.wkind = wr_kind;
    res.waddr = wr_addr;
    res.wval = wr_val;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    arch_view_t want;
    if (!rst_n) begin
      arch_pairs = '0;
      arch_sp = '0;
      mem_written = '0;
      arch_after_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (arch_after_q.size() == 0) begin
          $error("result returned with no request outstanding");
          fail_count = fail_count + 1;
        end else begin
          want = arch_after_q.pop_front();
          check_field("status", want.status, out_tdata[OUT_STATUS_LSB]);
          check_field("acc_out", want.acc, out_tdata[OUT_ACC_LSB +: 8]);
          check_field("flags_out", want.flags, out_tdata[OUT_FLAGS_LSB +: 8]);
          check_field("bc_out", want.bc, out_tdata[OUT_BC_LSB +: 16]);
          check_field("de_out", want.de, out_tdata[OUT_DE_LSB +: 16]);
          check_field("hl_out", want.hl, out_tdata[OUT_HL_LSB +: 16]);
          check_field("sp_out", want.sp, out_tdata[OUT_SP_LSB +: 16]);
          check_field("write_kind", want.wkind, out_tdata[OUT_WK_LSB +: 2]);
          check_field("write_address", want.waddr, out_tdata[OUT_WA_LSB +: 16]);
          check_field("write_value", want.wval, out_tdata[OUT_WV_LSB +: 16]);
        end
      end
      if (in_tvalid && in_tready)
        arch_after_q.push_back(execute_op(in_tdata[7:0], in_tdata[23:8]));
    end
    pending = arch_after_q.size();
  end

endmodule

FILE: tb/sv/tb_cpu_load_store_unit.sv
// Top of the load/store unit testbench: clock, reset, request stimulus and verdict.
// Depends on lsu_pkg, cpu_load_store_unit and lsu_result_checker.
module tb_cpu_load_store_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lsu_pkg::*;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LD_A_N   = 8'h3e;
  localparam logic [7:0] OP_PUSH_BC  = 8'hc5;
  localparam logic [7:0] OP_PUSH_DE  = 8'hd5;
  localparam logic [7:0] OP_POP_HL   = 8'he1;
  localparam logic [7:0] OP_POP_AF   = 8'hf1;

  localparam int RANDOM_REQUESTS = 650;
  localparam int IDLE_PCT = 32;

  localparam logic [18:0][7:0] MISC_OPS = {
    OP_LD_IBC_A, OP_LD_IDE_A, OP_LDI_HL_A, OP_LDD_HL_A, OP_LD_A_IBC, OP_LD_A_IDE,
    OP_LDI_A_HL, OP_LDD_A_HL, OP_LD_NN_SP, OP_LD_SP_HL, OP_LDH_N_A, OP_LDH_A_N,
    OP_LDH_C_A, OP_LDH_A_C, OP_LD_NN_A, OP_LD_A_NN, OP_LD_HL_SPE, OP_CCF, OP_SCF
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;

  int                   fail_count;
  int                   pending;
  pairs_t               arch_pairs;
  logic [15:0]          arch_sp;
  logic [MEM_DEPTH-1:0] mem_written;

  logic                 calm = 1'b0;
  logic [15:0]          addr_pool [8];

  cpu_load_store_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lsu_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .arch_pairs  (arch_pairs),
    .arch_sp     (arch_sp),
    .mem_written (mem_written)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("tb_cpu_load_store_unit: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send(input logic [7:0] op, input logic [15:0] imm);
    while (!calm && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {imm, op};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
  endtask

  // A load from memory that was never written is replaced by the matching store,
  // so a later load of the same kind finds the location filled.
  function automatic logic [7:0] safe_op(input logic [7:0] op, input logic [15:0] imm);
    logic [15:0] addr;
    logic [15:0] addr_hi;
    logic [7:0]  store_op;
    logic        word_rd;
    word_rd = 1'b0;
    addr = arch_pairs[PAIR_HL];
    store_op = op;
    if (op[7:6] == GRP_LD_R_R && op[2:0] == R8_MEM && op != OP_HALT) begin
      store_op = {GRP_LD_R_R, R8_MEM, op[5:3]};
    end else if ((op & MASK_PAIR) == PAT_POP) begin
      addr = arch_sp;
      word_rd = 1'b1;
      store_op = (op & ~MASK_PAIR) | PAT_PUSH;
    end else begin
      case (op)
        OP_LD_A_IBC: begin
          addr = arch_pairs[PAIR_BC];
          store_op = OP_LD_IBC_A;
        end
        OP_LD_A_IDE: begin
          addr = arch_pairs[PAIR_DE];
          store_op = OP_LD_IDE_A;
        end
        OP_LDI_A_HL: store_op = OP_LDI_HL_A;
        OP_LDD_A_HL: store_op = OP_LDD_HL_A;
        OP_LDH_A_N: begin
          addr = {HIGH_PAGE, imm[7:0]};
          store_op = OP_LDH_N_A;
        end
        OP_LDH_A_C: begin
          addr = {HIGH_PAGE, arch_pairs[PAIR_BC][7:0]};
          store_op = OP_LDH_C_A;
        end
        OP_LD_A_NN: begin
          addr = imm;
          store_op = OP_LD_NN_A;
        end
        default: ;
      endcase
    end
    addr_hi = addr + 16'd1;
    if (store_op == op || (mem_written[addr] && (!word_rd || mem_written[addr_hi])))
      return op;
    return store_op;
  endfunction

  task automatic pick_request(output logic [7:0] op, output logic [15:0] imm);
    int          kind;
    logic [1:0]  pair;
    logic [15:0] near;
    kind = $urandom_range(99);
    pair = 2'($urandom_range(3));
    imm = 16'($urandom);
    near = addr_pool[$urandom_range(7)] + 16'($urandom_range(3));
    if (kind < 12) begin
      op = 8'($urandom);
    end else if (kind < 30) begin
      op = PAT_LD_RR_NN | {2'b00, pair, 4'h0};
      if ($urandom_range(1) == 1) imm = near;
    end else if (kind < 55) begin
      op = {GRP_LD_R_R, 6'($urandom_range(63))};
    end else if (kind < 65) begin
      op = PAT_LD_R_N | {2'b00, 3'($urandom_range(7)), 3'b000};
    end else if (kind < 76) begin
      op = (($urandom_range(1) == 1) ? PAT_PUSH : PAT_POP) | {2'b00, pair, 4'h0};
    end else begin
      op = MISC_OPS[$urandom_range(18)];
      if ($urandom_range(9) < 7) imm = near;
    end
    op = safe_op(op, imm);
  endtask

  initial begin : stimulus
    logic [7:0]  op;
    logic [15:0] imm;
    int          waited;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hffff;
    addr_pool[2] = 16'hff80;
    addr_pool[3] = 16'hfffe;
    addr_pool[4] = 16'h8000;
    addr_pool[5] = 16'h7fff;
    addr_pool[6] = 16'($urandom);
    addr_pool[7] = {HIGH_PAGE, 8'($urandom)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_NOP, 16'hffff);
    send(OP_HALT, 16'h0000);
    send(OP_LD_SP_NN, 16'hffff);
    send(OP_LD_A_N, 16'h00ff);
    send(OP_SCF, 16'h0000);
    send(OP_CCF, 16'h0000);
    send(OP_CCF, 16'h0000);
    send(OP_LD_HL_NN, 16'hffff);
    send(OP_LDI_HL_A, 16'h0000);
    send(OP_LDD_HL_A, 16'h0000);
    send(OP_LDD_A_HL, 16'h0000);
    send(OP_LD_BC_NN, 16'h5aff);
    send(OP_LDH_C_A, 16'h0000);
    send(OP_LDH_A_C, 16'h0000);
    send(OP_LDH_N_A, 16'ha5ff);
    send(OP_LDH_A_N, 16'h12ff);
    send(OP_PUSH_BC, 16'h0000);
    send(OP_POP_AF, 16'h0000);
    send(OP_LD_NN_SP, 16'hffff);
    send(OP_LD_SP_NN, 16'h0001);
    send(OP_PUSH_DE, 16'h0000);
    send(OP_POP_HL, 16'h0000);
    send(OP_LD_SP_NN, 16'h00ff);
    send(OP_LD_HL_SPE, 16'h0081);
    send(OP_LD_SP_HL, 16'h0000);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      @(negedge clk);
      calm = (i >= 260 && i < 400);
      pick_request(op, imm);
      send(op, imm);
    end
    calm = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_cpu_load_store_unit: PASS");
    end else begin
      $display("tb_cpu_load_store_unit: FAIL");
    end
    $finish;
  end

endmodule
